// ===== hdl/mrgs_pkg.sv =====
// ---------------------------------------------------------------------------
// mrgs_pkg
// shared constants, the front-to-back queue entry and the sort order compare
// ---------------------------------------------------------------------------
package mrgs_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      keep;
        logic                      ovf;
        logic                      asc;
    } mrgs_entry_t;

    // true when a is emitted no later than b; ties favor a
    function automatic logic goes_first(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b,
        input logic                      asc
    );
        return asc ? (a <= b) : (a >= b);
    endfunction

endpackage

// ===== hdl/merge_sorter.sv =====
// ---------------------------------------------------------------------------
// merge_sorter
// collects a block of signed values, merge sorts it stably and replays it
// ---------------------------------------------------------------------------
// Items enter through a two-entry queue and are written to the element memory
// at one per cycle while the back end is loading; up to MAX_ITEMS are kept and
// the rest are dropped and flagged by overflow on every result of that block.
// When the item marked last_in has been stored, the block of n values is sorted
// by bottom-up merge passes that ping-pong between two memories: each pass reads
// and then compares and writes every element, with a setup step per pair of
// runs, for ceil(log2 n) passes. Results then leave through an output register.
// The single compare-and-write unit of the merge loop sets the sort speed, and a
// new block is loaded only once the last result has entered the output register.
// While a block is sorted or replayed, full rises once the queue has filled. The
// order bit (cfg_data, 1 = ascending) is sampled when the last item is accepted.
module merge_sorter
    import mrgs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last_in,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] sorted_value,
    output logic                      last_out,
    output logic                      overflow
);

    logic        q_wr;
    logic        q_rd;
    logic        q_full;
    logic        q_empty;
    mrgs_entry_t q_wdata;
    mrgs_entry_t q_rdata;

    assign full      = q_full;
    assign cfg_ready = 1'b1;

    mrgs_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .value     (value),
        .last_in   (last_in),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata)
    );

    mrgs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    mrgs_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_rd         (q_rd),
        .empty        (empty),
        .pop          (pop),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    a_no_read_when_empty : assert property (
        @(posedge clk) disable iff (!rst_n) q_rd |-> !q_empty
    ) else $error("queue read while empty");

    a_no_write_when_full : assert property (
        @(posedge clk) disable iff (!rst_n) q_wr |-> !q_full
    ) else $error("queue written while full");

    a_queue_count_moves : assert property (
        @(posedge clk) disable iff (!rst_n) (q_wr && !q_rd) |=> !q_empty
    ) else $error("queue empty after a write");

endmodule

// ===== hdl/mrgs_front.sv =====
// ---------------------------------------------------------------------------
// mrgs_front
// accepts input transactions, tracks block fill and overflow, holds the order
// register and tags each item for the back end
// ---------------------------------------------------------------------------
module mrgs_front
    import mrgs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last_in,
    input  logic                      cfg_valid,
    input  logic                      cfg_data,
    input  logic                      q_full,
    output logic                      q_wr,
    output mrgs_entry_t               q_wdata
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic          asc_reg;
    logic          keep;

    assign q_wr = push && !q_full;
    assign keep = count_reg < CW'(MAX_ITEMS);

    always_comb
    begin
        q_wdata.value = value;
        q_wdata.last  = last_in;
        q_wdata.keep  = keep;
        q_wdata.ovf   = ovf_reg || !keep;
        q_wdata.asc   = asc_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        if (q_wr)
        begin
            if (last_in)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_reg + CW'(keep);
                ovf_next   = ovf_reg || !keep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            asc_reg   <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_valid)
            begin
                asc_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== hdl/mrgs_queue.sv =====
// ---------------------------------------------------------------------------
// mrgs_queue
// two-entry queue between the front and back ends
// ---------------------------------------------------------------------------
module mrgs_queue
    import mrgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr,
    input  mrgs_entry_t wdata,
    output logic        full,
    input  logic        rd,
    output mrgs_entry_t rdata,
    output logic        empty
);

    mrgs_entry_t slot_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

// ===== hdl/mrgs_back.sv =====
// ---------------------------------------------------------------------------
// mrgs_back
// loads queued items into the element memory, runs bottom-up merge passes
// between two memories, and hands sorted results out through an output register
// ---------------------------------------------------------------------------
module mrgs_back
    import mrgs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  mrgs_entry_t               q_rdata,
    output logic                      q_rd,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [VALUE_W-1:0] sorted_value,
    output logic                      last_out,
    output logic                      overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 2;

    typedef enum logic [5:0] {
        S_LOAD      = 6'b000001,
        S_SETUP     = 6'b000010,
        S_READ      = 6'b000100,
        S_MERGE     = 6'b001000,
        S_EMIT_RD   = 6'b010000,
        S_EMIT_WAIT = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic          ovf_reg, ovf_next;
    logic          asc_reg, asc_next;
    logic          parity_reg, parity_next;
    logic [PW-1:0] width_reg, width_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] i_reg, i_next;
    logic [PW-1:0] mid_reg, mid_next;
    logic [PW-1:0] j_reg, j_next;
    logic [PW-1:0] hi_reg, hi_next;
    logic [PW-1:0] k_reg, k_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;

    logic signed [VALUE_W-1:0] mem_a [MAX_ITEMS];
    logic signed [VALUE_W-1:0] mem_b [MAX_ITEMS];
    logic signed [VALUE_W-1:0] rd_ai_reg, rd_aj_reg, rd_bi_reg, rd_bj_reg;

    logic                      a_we, b_we;
    logic [AW-1:0]             a_waddr;
    logic signed [VALUE_W-1:0] a_wdata;

    logic signed [VALUE_W-1:0] head_i, head_j, merge_val;
    logic [PW-1:0]             n_ext, lo_w, lo_2w, mid_c, hi_c, w2, i_m, j_m;
    logic [CW-1:0]             n_new;
    logic                      take_i, run_done, out_load;

    assign empty        = !out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_out     = out_last_reg;
    assign overflow     = out_ovf_reg;

    assign q_rd     = (state_reg == S_LOAD) && !q_empty;
    assign out_load = !out_valid_reg || pop;

    assign head_i    = parity_reg ? rd_bi_reg : rd_ai_reg;
    assign head_j    = parity_reg ? rd_bj_reg : rd_aj_reg;
    assign n_ext     = PW'(n_reg);
    assign lo_w      = lo_reg + width_reg;
    assign w2        = width_reg << 1;
    assign lo_2w     = lo_reg + w2;
    assign mid_c     = (lo_w > n_ext) ? n_ext : lo_w;
    assign hi_c      = (lo_2w > n_ext) ? n_ext : lo_2w;
    assign n_new     = load_cnt_reg + CW'(q_rdata.keep);
    assign take_i    = (i_reg < mid_reg)
                       && ((j_reg >= hi_reg) || goes_first(head_i, head_j, asc_reg));
    assign merge_val = take_i ? head_i : head_j;
    assign i_m       = i_reg + PW'(take_i);
    assign j_m       = j_reg + PW'(!take_i);
    assign run_done  = (i_m == mid_reg) && (j_m == hi_reg);

    assign a_we    = (q_rd && q_rdata.keep) || ((state_reg == S_MERGE) && parity_reg);
    assign b_we    = (state_reg == S_MERGE) && !parity_reg;
    assign a_waddr = (state_reg == S_LOAD) ? load_cnt_reg[AW-1:0] : k_reg[AW-1:0];
    assign a_wdata = (state_reg == S_LOAD) ? q_rdata.value : merge_val;

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_waddr] <= a_wdata;
        end
        if (b_we)
        begin
            mem_b[k_reg[AW-1:0]] <= merge_val;
        end
        rd_ai_reg <= mem_a[i_reg[AW-1:0]];
        rd_aj_reg <= mem_a[j_reg[AW-1:0]];
        rd_bi_reg <= mem_b[i_reg[AW-1:0]];
        rd_bj_reg <= mem_b[j_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        asc_next       = asc_reg;
        parity_next    = parity_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        i_next         = i_reg;
        mid_next       = mid_reg;
        j_next         = j_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (q_rd)
                begin
                    load_cnt_next = n_new;
                    if (q_rdata.last)
                    begin
                        load_cnt_next = '0;
                        n_next        = n_new;
                        ovf_next      = q_rdata.ovf;
                        asc_next      = q_rdata.asc;
                        parity_next   = 1'b0;
                        width_next    = PW'(1);
                        lo_next       = '0;
                        k_next        = '0;
                        i_next        = '0;
                        state_next    = (n_new <= CW'(1)) ? S_EMIT_RD : S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                i_next     = lo_reg;
                mid_next   = mid_c;
                j_next     = mid_c;
                hi_next    = hi_c;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                i_next     = i_m;
                j_next     = j_m;
                k_next     = k_reg + PW'(1);
                state_next = S_READ;
                if (run_done)
                begin
                    lo_next    = hi_reg;
                    state_next = S_SETUP;
                    // pass complete
                    if (hi_reg == n_ext)
                    begin
                        parity_next = !parity_reg;
                        width_next  = w2;
                        lo_next     = '0;
                        k_next      = '0;
                        if (w2 >= n_ext)
                        begin
                            i_next     = '0;
                            state_next = S_EMIT_RD;
                        end
                    end
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = head_i;
                    out_last_next  = (i_reg + PW'(1)) == n_ext;
                    out_ovf_next   = ovf_reg;
                    i_next         = i_reg + PW'(1);
                    state_next     = ((i_reg + PW'(1)) == n_ext) ? S_LOAD : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        ovf_reg       <= ovf_next;
        asc_reg       <= asc_next;
        parity_reg    <= parity_next;
        width_reg     <= width_next;
        lo_reg        <= lo_next;
        i_reg         <= i_next;
        mid_reg       <= mid_next;
        j_reg         <= j_next;
        hi_reg        <= hi_next;
        k_reg         <= k_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

endmodule

// ===== bench/tb_merge_sorter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_merge_sorter
// self-checking bench for the merge sorter
// ---------------------------------------------------------------------------
// Sends blocks of signed values through the push/full side and predicts
// every sorted block with a stable insertion sort in the chosen order. The
// prediction includes the overflow flag for blocks longer than the buffer.
// Each popped transaction is checked field by field against the oldest
// prediction. Blocks are directed extremes, full and overflowing blocks, and
// then random blocks of mostly small sizes. The order bit is rewritten
// between blocks. Both sides idle in random bursts, except in the last part.
// ---------------------------------------------------------------------------
module tb_merge_sorter;
    import mrgs_pkg::*;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam bit ORDER_UP   = 1'b1;
    localparam bit ORDER_DOWN = 1'b0;
    localparam int CFG_SETTLE = 40;
    localparam int END_SETTLE = 200;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      ovf;
    } sorted_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_data;
    logic                      empty;
    logic                      pop;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;

    sorted_result_t            sorted_q[$];
    logic signed [VALUE_W-1:0] block_buf[$];
    bit                        block_ovf;
    bit                        order_asc;
    bit                        idle_on;
    int                        fail_count;
    int                        pop_hold;

    merge_sorter #(
        .MAX_ITEMS (MAX_ITEMS_DEF)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .value        (value),
        .last_in      (last_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .empty        (empty),
        .pop          (pop),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // stable sort of the closed block into the expected transactions
    function automatic void close_block();
        logic signed [VALUE_W-1:0] key;
        int                        j;
        sorted_result_t            r;
        for (int i = 1; i < block_buf.size(); i++)
        begin
            key = block_buf[i];
            j = i - 1;
            while (j >= 0 && (order_asc ? (key < block_buf[j]) : (key > block_buf[j])))
            begin
                block_buf[j + 1] = block_buf[j];
                j--;
            end
            block_buf[j + 1] = key;
        end
        for (int k = 0; k < block_buf.size(); k++)
        begin
            r.value = block_buf[k];
            r.last  = (k == block_buf.size() - 1);
            r.ovf   = block_ovf;
            sorted_q.insert(sorted_q.size(), r);
        end
        block_buf.delete();
        block_ovf = 1'b0;
    endfunction

    function automatic void add_element(input logic signed [VALUE_W-1:0] v, input bit last);
        if (block_buf.size() < MAX_ITEMS_DEF)
            block_buf.insert(block_buf.size(), v);
        else
            block_ovf = 1'b1;
        if (last)
            close_block();
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    // push stays high after the transaction; the next call moves or lowers it
    task automatic send_element(input logic signed [VALUE_W-1:0] v, input bit last);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    = 1'b1;
        value   = v;
        last_in = last;
        do @(posedge clk); while (full);
        add_element(v, last);
    endtask

    task automatic idle_sender();
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic wait_drained();
        idle_sender();
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_order(input bit asc);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = asc;
        do @(posedge clk); while (!cfg_ready);
        order_asc = asc;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_block(input int n);
        for (int i = 0; i < n; i++)
            send_element(pick_value(), i == n - 1);
    endtask

    task automatic send_extremes_block();
        logic signed [VALUE_W-1:0] mix[9];
        mix = '{VAL_MAX, VAL_MIN, 0, -1, 1, 5, -5, 5, 0};
        for (int i = 0; i < 9; i++)
            send_element(mix[i], i == 8);
    endtask

    task automatic test_ascending();
        write_order(ORDER_UP);
        send_element(VAL_MIN, 1'b1);
        send_extremes_block();
        send_element(1, 1'b0);
        send_element(-1, 1'b1);
    endtask

    task automatic test_descending();
        write_order(ORDER_DOWN);
        send_element(VAL_MAX, 1'b1);
        send_extremes_block();
        send_element(-1, 1'b0);
        send_element(1, 1'b1);
    endtask

    // exactly full, then a block whose closing transaction is dropped
    task automatic test_capacity();
        write_order(ORDER_UP);
        send_random_block(MAX_ITEMS_DEF);
        write_order(ORDER_DOWN);
        send_random_block(MAX_ITEMS_DEF + 2);
    endtask

    task automatic test_random_blocks();
        int sent;
        int blocks;
        int pick;
        int n;
        sent = 0;
        blocks = 0;
        while (sent < 130)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 17)
                n = $urandom_range(1, 8);
            else if (pick < 19)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(MAX_ITEMS_DEF - 2, MAX_ITEMS_DEF + 4);
            send_random_block(n);
            sent += n;
            blocks++;
            if (blocks % 6 == 0)
                write_order(1'($urandom_range(0, 1)));
            else if (blocks == 9)
                wait_drained();
        end
    endtask

    task automatic test_no_idle();
        int sent;
        int n;
        idle_on = 1'b0;
        write_order(ORDER_UP);
        sent = 0;
        while (sent < 40)
        begin
            n = $urandom_range(1, 8);
            send_random_block(n);
            sent += n;
        end
    endtask

    initial
    begin
        pop = 1'b0;
        pop_hold = 0;
        forever
        begin
            @(negedge clk);
            if (pop_hold > 0)
            begin
                pop = 1'b0;
                pop_hold--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                pop = 1'b0;
                pop_hold = $urandom_range(0, 6);
            end
            else
                pop = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_result
        sorted_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (sorted_q.size() == 0)
            begin
                $error("unexpected transaction: sorted_value %0d", sorted_value);
                fail_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (sorted_value !== want.value)
                begin
                    $error("sorted_value: expected %0d, actual %0d", want.value, sorted_value);
                    fail_count++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out: expected %0b, actual %0b", want.last, last_out);
                    fail_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, actual %0b", want.ovf, overflow);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        push       = 1'b0;
        value      = '0;
        last_in    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = ORDER_UP;
        idle_on    = 1'b1;
        order_asc  = ORDER_UP;
        block_ovf  = 1'b0;
        fail_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ascending();
        test_descending();
        test_capacity();
        test_random_blocks();
        test_no_idle();

        idle_sender();
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mrgs_pkg.sv
hdl/mrgs_front.sv
hdl/mrgs_queue.sv
hdl/mrgs_back.sv
hdl/merge_sorter.sv
bench/tb_merge_sorter.sv
